// ----- rtl/core/srpd_pkg.sv -----
// shared types and constants for the stuck register poll detector
package srpd_pkg;

  localparam int ADDR_W     = 32;
  localparam int DATA_W     = 32;
  localparam int TIME_W     = 64;
  localparam int COUNT_W    = 32;
  localparam int CFG_W      = 32;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_IDX_W  = 1;

  // register indexes, taken from paddr[2]
  localparam logic [CFG_IDX_W-1:0] REG_STUCK_THRESHOLD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_CYCLES   = 1'b1;

  localparam logic [CFG_W-1:0] THRESHOLD_RESET = 32'd500000;
  localparam logic [CFG_W-1:0] WINDOW_RESET    = 32'd33868800;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef struct packed {
    logic [ADDR_W-1:0] read_address;
    logic [DATA_W-1:0] read_value;
    logic [TIME_W-1:0] now_cycle;
  } item_t;

  typedef struct packed {
    logic               stuck_report;
    logic [ADDR_W-1:0]  report_address;
    logic [COUNT_W-1:0] report_count;
    logic [DATA_W-1:0]  report_value;
  } result_t;

  typedef struct packed {
    logic [CFG_W-1:0] stuck_threshold;
    logic [CFG_W-1:0] window_cycles;
  } cfg_t;

endpackage

// ----- rtl/core/stuck_register_poll_detector_top.sv -----
// top level of the stuck register poll detector
//
// watches a stream of register read beats (address, returned value, cycle
// timestamp) and raises one report beat per tracking when a single address
// is read stuck_threshold times within window_cycles cycles. every input beat
// yields exactly one output beat; out_stuck_report marks the one that fires,
// and its address, count and value fields are zero otherwise. the block takes
// one beat per clock while in_stall is low: a beat is held in the input
// register, then the decision logic (64-bit window subtract and compare,
// 32-bit address compare, count increment and threshold compare) updates the
// tracking state and loads the result register on the same edge, so the
// following beat already sees the updated state. in_stall rises only when
// both registers are full and the sink holds out_stall. the user must write
// threshold and window at apb byte addresses 0 and 4 only while no beat is in
// flight; the block does not check it. there is no clearing pass after reset.
module stuck_register_poll_detector_top (
  input  logic                             clk,
  input  logic                             rst_n,
  // input read beats
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [srpd_pkg::ADDR_W-1:0]      in_read_address,
  input  logic [srpd_pkg::DATA_W-1:0]      in_read_value,
  input  logic [srpd_pkg::TIME_W-1:0]      in_now_cycle,
  // result beats
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_stuck_report,
  output logic [srpd_pkg::ADDR_W-1:0]      out_report_address,
  output logic [srpd_pkg::COUNT_W-1:0]     out_report_count,
  output logic [srpd_pkg::DATA_W-1:0]      out_report_value,
  // configuration
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [srpd_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [srpd_pkg::CFG_W-1:0]       pwdata,
  output logic [srpd_pkg::CFG_W-1:0]       prdata,
  output logic                             pready
);
  import srpd_pkg::*;

  cfg_t    cfg;
  item_t   s1_item_r;
  logic    s1_valid_r;
  logic    s1_valid_nxt;
  result_t out_res_r;
  result_t res;
  logic    out_valid_r;
  logic    out_valid_nxt;
  logic    in_take;
  logic    advance;

  srpd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // held beat moves on when the result register is empty or being drained
  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  srpd_track u_track (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .step   (advance),
    .item   (s1_item_r),
    .result (res)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r.read_address <= in_read_address;
      s1_item_r.read_value   <= in_read_value;
      s1_item_r.now_cycle    <= in_now_cycle;
    end
    if (advance) begin
      out_res_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_stuck_report   = out_res_r.stuck_report;
  assign out_report_address = out_res_r.report_address;
  assign out_report_count   = out_res_r.report_count;
  assign out_report_value   = out_res_r.report_value;

endmodule

// ----- rtl/core/srpd_cfg.sv -----
// apb register file holding threshold and window length
module srpd_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [srpd_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [srpd_pkg::CFG_W-1:0]       pwdata,
  output logic [srpd_pkg::CFG_W-1:0]       prdata,
  output logic                             pready,
  output srpd_pkg::cfg_t                   cfg
);
  import srpd_pkg::*;

  logic [CFG_W-1:0]     threshold_r;
  logic [CFG_W-1:0]     window_r;
  logic [CFG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  assign reg_idx = paddr[2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= THRESHOLD_RESET;
      window_r    <= WINDOW_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_STUCK_THRESHOLD: threshold_r <= pwdata;
        REG_WINDOW_CYCLES:   window_r    <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_STUCK_THRESHOLD: prdata = threshold_r;
      REG_WINDOW_CYCLES:   prdata = window_r;
      default:             prdata = '0;
    endcase
  end

  assign cfg.stuck_threshold = threshold_r;
  assign cfg.window_cycles   = window_r;

endmodule

// ----- rtl/core/srpd_track.sv -----
// tracking state and the single-pass decision for one read
module srpd_track (
  input  logic               clk,
  input  logic               rst_n,
  input  srpd_pkg::cfg_t     cfg,
  input  logic               step,
  input  srpd_pkg::item_t    item,
  output srpd_pkg::result_t  result
);
  import srpd_pkg::*;

  logic [ADDR_W-1:0]  tracked_r;
  logic [TIME_W-1:0]  start_r;
  logic [COUNT_W-1:0] count_r;
  logic               reported_r;

  logic [TIME_W-1:0]  elapsed;
  logic               addr_match;
  logic               expired;
  logic               ignore;
  logic               restart;
  logic [COUNT_W-1:0] count_nxt;
  logic               reported_base;
  logic               fire;

  assign addr_match = (item.read_address == tracked_r);
  // modulo difference, a backwards timestamp wraps and ends the window
  assign elapsed    = item.now_cycle - start_r;
  assign expired    = elapsed > {{(TIME_W-CFG_W){1'b0}}, cfg.window_cycles};
  assign ignore     = !addr_match && (count_r != '0) && !expired;
  assign restart    = !addr_match || expired;

  always_comb begin
    if (restart) begin
      count_nxt = {{(COUNT_W-1){1'b0}}, 1'b1};
    end else if (count_r == COUNT_MAX) begin
      count_nxt = count_r;
    end else begin
      count_nxt = count_r + {{(COUNT_W-1){1'b0}}, 1'b1};
    end
  end

  // a new address rearms the report
  assign reported_base = addr_match && reported_r;
  assign fire = !ignore && !reported_base && (count_nxt >= cfg.stuck_threshold);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tracked_r  <= '0;
      start_r    <= '0;
      count_r    <= '0;
      reported_r <= 1'b0;
    end else if (step && !ignore) begin
      tracked_r  <= item.read_address;
      count_r    <= count_nxt;
      reported_r <= reported_base || fire;
      if (restart) begin
        start_r <= item.now_cycle;
      end
    end
  end

  always_comb begin
    result = '0;
    if (fire) begin
      result.stuck_report   = 1'b1;
      result.report_address = item.read_address;
      result.report_count   = count_nxt;
      result.report_value   = item.read_value;
    end
  end

endmodule

// ----- rtl/core/srpd_chk.sv -----
// port-level checker for the stuck register poll detector, with its bind
module srpd_chk (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic                             out_stuck_report,
  input logic [srpd_pkg::ADDR_W-1:0]      out_report_address,
  input logic [srpd_pkg::COUNT_W-1:0]     out_report_count,
  input logic [srpd_pkg::DATA_W-1:0]      out_report_value
);
  import srpd_pkg::*;

  // stalled result beat stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  // stalled result payload holds
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_stuck_report) &&
      $stable(out_report_address) && $stable(out_report_count) &&
      $stable(out_report_value))
    else $error("result payload changed while stalled");

  // fields are zero on beats that do not report
  a_quiet_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stuck_report |-> out_report_address == '0 &&
      out_report_count == '0 && out_report_value == '0)
    else $error("nonzero fields on a beat without report");

  // a report always carries at least the read that fired it
  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stuck_report |-> out_report_count != '0)
    else $error("report with zero count");

  // with the result register empty the input never stalls
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty result register");

endmodule

bind stuck_register_poll_detector_top srpd_chk u_srpd_chk (.*);
